// ===== hw/rtl/dtf_pkg.sv =====
// Package for the distance to focus interpolator.
// Holds the beat types, the operation and register codes, and the controller/datapath interface.
// It depends on nothing else.
package dtf_pkg;

  localparam int FOCUS_W    = 10;
  localparam int DIST_W     = 20;
  localparam int OP_W       = 2;
  localparam int TOTAL_W    = 5;
  localparam int VAL_W      = FOCUS_W + 2;
  localparam int CFG_ADDR_W = 1;

  localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd1;
  localparam logic [OP_W-1:0] OP_DIST   = 2'd2;
  localparam logic [OP_W-1:0] OP_DIRECT = 2'd3;

  localparam logic [CFG_ADDR_W-1:0] REG_MIN_FOCUS = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_FOCUS = 1'd1;

  localparam logic [FOCUS_W-1:0] MAX_FOCUS_RESET = 10'd1023;

  localparam logic [DIST_W-1:0] MAP_START = 20'd800;
  localparam logic [DIST_W-1:0] MAP_END   = 20'd16000;
  localparam logic [DIST_W-1:0] MAP_SPAN  = 20'd15200;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [DIST_W-1:0]  distance;
    logic [FOCUS_W-1:0] focus_in;
  } in_item_t;

  typedef struct packed {
    logic [FOCUS_W-1:0] focus;
    logic               status;
    logic [TOTAL_W-1:0] point_total;
  } out_item_t;

  typedef struct packed {
    logic [DIST_W-1:0]  distance;
    logic [FOCUS_W-1:0] focus;
  } entry_t;

  typedef struct packed {
    logic load;
    logic rd_shift;
    logic step;
    logic cap_cur;
    logic wr_hit;
    logic wr_new;
    logic wr_shift;
    logic set_full;
    logic prep;
    logic div_start;
    logic fin;
  } ctl_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            idx_at_count;
    logic            sk_at_idx;
    logic            ge;
    logic            eq;
    logic            full;
    logic            use_div;
    logic            div_busy;
  } dp_stat_t;

  function automatic logic [FOCUS_W-1:0] bound_focus(logic signed [VAL_W-1:0] v,
                                                     logic [FOCUS_W-1:0] lo,
                                                     logic [FOCUS_W-1:0] hi);
    logic signed [VAL_W-1:0] r;
    r = v;
    if (r > $signed({2'b00, hi})) begin
      r = $signed({2'b00, hi});
    end
    if (r < $signed({2'b00, lo})) begin
      r = $signed({2'b00, lo});
    end
    return r[FOCUS_W-1:0];
  endfunction

endpackage

// ===== hw/rtl/dtf_ram.sv =====
// Generic single write port RAM with one registered read port.
// Used for the calibration table; no dependencies.
module dtf_ram #(
  parameter int WIDTH = 30,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/dtf_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Used by the datapath for the interpolation step; no dependencies.
module dtf_div #(
  parameter int NW = 30,
  parameter int DW = 20
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [NW-1:0] quo,
  output logic [DW-1:0] rem,
  output logic          busy
);

  localparam int CNT_W = $clog2(NW + 1);

  logic [CNT_W-1:0] cnt;
  logic [DW-1:0]    den_q;
  logic [DW:0]      trial;
  logic             fits;

  assign trial = {rem, quo[NW-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(NW);
    end else if (busy) begin
      cnt  <= cnt - 1'b1;
      busy <= cnt != CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo   <= num;
      rem   <= '0;
      den_q <= den;
    end else if (busy) begin
      quo <= {quo[NW-2:0], fits};
      rem <= fits ? DW'(trial - {1'b0, den_q}) : trial[DW-1:0];
    end
  end

endmodule

// ===== hw/rtl/dtf_datapath.sv =====
// Datapath: item registers, calibration table, scan pointers, multiplier, divider and result.
// Depends on dtf_pkg, dtf_ram and dtf_div; commanded by dtf_ctrl.
module dtf_datapath #(
  parameter int MAX_POINTS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  dtf_pkg::ctl_cmd_t                   cmd,
  output dtf_pkg::dp_stat_t                   stat,
  input  dtf_pkg::in_item_t                   req,
  input  logic                                cfg_we,
  input  logic [dtf_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [dtf_pkg::FOCUS_W-1:0]         cfg_data,
  output dtf_pkg::out_item_t                  rsp
);
  import dtf_pkg::*;

  localparam int AW    = $clog2(MAX_POINTS);
  localparam int CW    = $clog2(MAX_POINTS + 1);
  localparam int MAG_W = DIST_W + FOCUS_W;

  logic [OP_W-1:0]    op_q;
  logic [DIST_W-1:0]  d_q;
  logic [FOCUS_W-1:0] f_q;
  logic [CW-1:0]      idx;
  logic [CW-1:0]      sk;
  logic [CW-1:0]      count;
  entry_t             prev;
  entry_t             cur;
  entry_t             rdata;
  logic [FOCUS_W-1:0] min_focus;
  logic [FOCUS_W-1:0] max_focus;
  logic [FOCUS_W-1:0] cur_focus;
  logic               status_q;

  logic                    use_div;
  logic                    neg;
  logic [FOCUS_W-1:0]      base;
  logic [DIST_W-1:0]       den;
  logic [MAG_W-1:0]        mag;
  logic signed [VAL_W-1:0] v_dir;

  logic                    p_use;
  logic signed [VAL_W-1:0] p_dir;
  logic [DIST_W-1:0]       p_a;
  logic signed [FOCUS_W:0] p_df;
  logic [FOCUS_W-1:0]      p_base;
  logic [DIST_W-1:0]       p_den;
  logic [FOCUS_W-1:0]      abs_df;
  logic [MAG_W-1:0]        p_mag;

  logic [MAG_W-1:0]        div_q;
  logic [DIST_W-1:0]       div_r;
  logic                    div_busy;

  logic [VAL_W-1:0]        qmag;
  logic signed [VAL_W-1:0] qs;
  logic signed [VAL_W-1:0] v_res;
  logic [FOCUS_W-1:0]      focus_new;
  logic [CW-1:0]           count_new;

  logic                    we;
  logic [AW-1:0]           waddr;
  entry_t                  wdata;
  logic [AW-1:0]           raddr;
  logic [CW-1:0]           sk_m1;

  assign sk_m1 = sk - 1'b1;
  assign raddr = cmd.rd_shift ? sk_m1[AW-1:0] : idx[AW-1:0];
  assign we    = cmd.wr_hit | cmd.wr_new | cmd.wr_shift;
  assign waddr = cmd.wr_shift ? sk[AW-1:0] : idx[AW-1:0];
  assign wdata = cmd.wr_shift ? rdata : entry_t'{distance: d_q, focus: f_q};

  dtf_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(MAX_POINTS)
  ) u_table (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  dtf_div #(
    .NW(MAG_W),
    .DW(DIST_W)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(cmd.div_start),
    .num  (mag),
    .den  (den),
    .quo  (div_q),
    .rem  (div_r),
    .busy (div_busy)
  );

  always_comb begin
    p_use  = 1'b0;
    p_dir  = '0;
    p_a    = '0;
    p_df   = '0;
    p_base = '0;
    p_den  = MAP_SPAN;
    if (count == '0) begin
      if (d_q <= MAP_START) begin
        p_dir = $signed({2'b00, min_focus});
      end else if (d_q >= MAP_END) begin
        p_dir = $signed({2'b00, max_focus});
      end else begin
        p_use  = 1'b1;
        p_a    = d_q - MAP_START;
        p_df   = $signed({1'b0, max_focus}) - $signed({1'b0, min_focus});
        p_base = min_focus;
      end
    end else if (idx == count) begin
      p_dir = $signed({2'b00, prev.focus});
    end else if (idx == '0) begin
      p_dir = $signed({2'b00, cur.focus});
    end else if (cur.distance <= prev.distance) begin
      p_dir = $signed({2'b00, prev.focus});
    end else begin
      p_use  = 1'b1;
      p_a    = d_q - prev.distance;
      p_df   = $signed({1'b0, cur.focus}) - $signed({1'b0, prev.focus});
      p_base = prev.focus;
      p_den  = cur.distance - prev.distance;
    end
  end

  assign abs_df = p_df[FOCUS_W] ? FOCUS_W'(-p_df) : p_df[FOCUS_W-1:0];
  assign p_mag  = {{FOCUS_W{1'b0}}, p_a} * {{DIST_W{1'b0}}, abs_df};

  assign qmag  = {2'b00, div_q[FOCUS_W-1:0]} + VAL_W'(div_r != '0);
  assign qs    = neg ? -$signed(qmag) : $signed({2'b00, div_q[FOCUS_W-1:0]});
  assign v_res = use_div ? $signed({2'b00, base}) + qs : v_dir;

  always_comb begin
    focus_new = cur_focus;
    count_new = count;
    unique case (op_q)
      OP_CLEAR:  count_new = '0;
      OP_DIRECT: focus_new = bound_focus($signed({2'b00, f_q}), min_focus, max_focus);
      OP_DIST:   focus_new = bound_focus(v_res, min_focus, max_focus);
      default:   count_new = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_focus <= '0;
      max_focus <= MAX_FOCUS_RESET;
      count     <= '0;
      cur_focus <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_MIN_FOCUS: min_focus <= cfg_data;
          REG_MAX_FOCUS: max_focus <= cfg_data;
          default:       min_focus <= min_focus;
        endcase
      end
      if (cmd.wr_new) begin
        count <= count + 1'b1;
      end else if (cmd.fin) begin
        count     <= count_new;
        cur_focus <= focus_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q     <= req.op;
      d_q      <= req.distance;
      f_q      <= req.focus_in;
      idx      <= '0;
      sk       <= count;
      status_q <= 1'b0;
    end else begin
      if (cmd.step) begin
        prev <= rdata;
        idx  <= idx + 1'b1;
      end
      if (cmd.wr_shift) begin
        sk <= sk_m1;
      end
      if (cmd.set_full) begin
        status_q <= 1'b1;
      end
    end
    if (cmd.cap_cur) begin
      cur <= rdata;
    end
    if (cmd.prep) begin
      use_div <= p_use;
      v_dir   <= p_dir;
      neg     <= p_df[FOCUS_W];
      base    <= p_base;
      den     <= p_den;
      mag     <= p_mag;
    end
    if (cmd.fin) begin
      rsp.focus       <= focus_new;
      rsp.status      <= status_q;
      rsp.point_total <= TOTAL_W'(count_new);
    end
  end

  assign stat.op           = op_q;
  assign stat.idx_at_count = idx == count;
  assign stat.sk_at_idx    = sk == idx;
  assign stat.ge           = rdata.distance >= d_q;
  assign stat.eq           = rdata.distance == d_q;
  assign stat.full         = count == CW'(MAX_POINTS);
  assign stat.use_div      = use_div;
  assign stat.div_busy     = div_busy;

endmodule

// ===== hw/rtl/dtf_ctrl.sv =====
// Controller state machine: sequences scan, insert, interpolation and result beat.
// Depends on dtf_pkg; drives the commands of dtf_datapath.
module dtf_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  input  dtf_pkg::dp_stat_t stat,
  output dtf_pkg::ctl_cmd_t cmd
);
  import dtf_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_RD     = 4'd1;
  localparam logic [3:0] S_CHK    = 4'd2;
  localparam logic [3:0] S_SH_TST = 4'd3;
  localparam logic [3:0] S_SH_RD  = 4'd4;
  localparam logic [3:0] S_SH_WR  = 4'd5;
  localparam logic [3:0] S_PREP   = 4'd6;
  localparam logic [3:0] S_DIVGO  = 4'd7;
  localparam logic [3:0] S_DIV    = 4'd8;
  localparam logic [3:0] S_FIN    = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       out_free;

  assign req_stall = state != S_IDLE;
  assign out_free  = !(rsp_valid && rsp_stall);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_RD;
        end
      end
      S_RD: begin
        if (stat.op == OP_CLEAR || stat.op == OP_DIRECT) begin
          state_next = S_FIN;
        end else if (stat.idx_at_count) begin
          if (stat.op == OP_DIST) begin
            state_next = S_PREP;
          end else if (stat.full) begin
            cmd.set_full = 1'b1;
            state_next   = S_FIN;
          end else begin
            state_next = S_SH_TST;
          end
        end else begin
          state_next = S_CHK;
        end
      end
      S_CHK: begin
        if (stat.ge) begin
          cmd.cap_cur = 1'b1;
          if (stat.op == OP_DIST) begin
            state_next = S_PREP;
          end else if (stat.eq) begin
            cmd.wr_hit = 1'b1;
            state_next = S_FIN;
          end else if (stat.full) begin
            cmd.set_full = 1'b1;
            state_next   = S_FIN;
          end else begin
            state_next = S_SH_TST;
          end
        end else begin
          cmd.step   = 1'b1;
          state_next = S_RD;
        end
      end
      S_SH_TST: begin
        if (stat.sk_at_idx) begin
          cmd.wr_new = 1'b1;
          state_next = S_FIN;
        end else begin
          state_next = S_SH_RD;
        end
      end
      S_SH_RD: begin
        cmd.rd_shift = 1'b1;
        state_next   = S_SH_WR;
      end
      S_SH_WR: begin
        cmd.wr_shift = 1'b1;
        state_next   = S_SH_TST;
      end
      S_PREP: begin
        cmd.prep   = 1'b1;
        state_next = S_DIVGO;
      end
      S_DIVGO: begin
        if (stat.use_div) begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end else begin
          state_next = S_FIN;
        end
      end
      S_DIV: begin
        if (!stat.div_busy) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          cmd.fin    = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.fin) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> state == S_RD)
    else $error("accepted beat did not start the scan");

  a_beat_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) == S_FIN)
    else $error("result beat raised outside the finish step");

  a_shift_pairs: assert property (@(posedge clk) disable iff (rst)
    state == S_SH_WR |-> $past(state) == S_SH_RD)
    else $error("table shift write without its read");

  a_div_wait: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> $past(state) == S_DIVGO || $past(state) == S_DIV)
    else $error("divider wait entered out of order");

endmodule

// ===== hw/rtl/distance_to_focus_interpolator.sv =====
// Distance to focus interpolator: one beat in, one result beat out, one item at a time.
// A new item is taken only after the last one has raised its result beat.
// Clear and direct go to finish; add compares keys in turn, then shifts larger keys up.
// Focus from distance compares keys in turn, then runs the divider when it interpolates.
// The next beat is taken while a result beat still waits on a stall.
// Synchronous reset empties the table count, zeroes the focus and sets min 0, max 1023.
module distance_to_focus_interpolator #(
  parameter int MAX_POINTS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_stall,
  input  dtf_pkg::in_item_t              req,
  output logic                           rsp_valid,
  input  logic                           rsp_stall,
  output dtf_pkg::out_item_t             rsp,
  input  logic                           cfg_we,
  input  logic [dtf_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [dtf_pkg::FOCUS_W-1:0]    cfg_data
);
  import dtf_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  dtf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  dtf_datapath #(
    .MAX_POINTS(MAX_POINTS)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .stat    (stat),
    .req     (req),
    .cfg_we  (cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_data(cfg_data),
    .rsp     (rsp)
  );

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for distance_to_focus_interpolator: queued beats, random gaps and stalls.
// Predicts each result beat from its own table model; depends on dtf_pkg and the RTL top.
`timescale 1ns / 100ps

module tb_top;
  import dtf_pkg::*;

  localparam int NPTS = 16;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  in_item_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  out_item_t rsp;
  logic cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [FOCUS_W-1:0] cfg_data = '0;

  distance_to_focus_interpolator #(.MAX_POINTS(NPTS)) u_top (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  logic [DIST_W-1:0] tab_dist [NPTS];
  logic [FOCUS_W-1:0] tab_focus [NPTS];
  int tab_count = 0;
  logic [FOCUS_W-1:0] cur_focus = '0;
  logic [FOCUS_W-1:0] lim_lo = '0;
  logic [FOCUS_W-1:0] lim_hi = MAX_FOCUS_RESET;

  in_item_t pending_beats[$];
  out_item_t expected_rsp[$];
  int errors = 0;
  bit hold_sender = 1'b0;
  bit in_taken = 1'b0;
  int burst_left = 0;
  int gap_left = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic longint floor_quot(longint num, longint den);
    longint q;
    q = num / den;
    if ((num % den) != 0 && num < 0) q--;
    return q;
  endfunction

  function automatic logic [FOCUS_W-1:0] clamp_focus(longint v);
    if (v > longint'(lim_hi)) v = longint'(lim_hi);
    if (v < longint'(lim_lo)) v = longint'(lim_lo);
    return v[FOCUS_W-1:0];
  endfunction

  function automatic longint lookup_focus(logic [DIST_W-1:0] d);
    int i;
    longint dl, du, fl, fu;
    if (tab_count == 0) begin
      if (d <= MAP_START) return longint'(lim_lo);
      if (d >= MAP_END) return longint'(lim_hi);
      return longint'(lim_lo) + floor_quot(longint'(d - MAP_START) *
             (longint'(lim_hi) - longint'(lim_lo)), longint'(MAP_SPAN));
    end
    if (tab_count == 1) return longint'(tab_focus[0]);
    i = 0;
    while (i < tab_count && tab_dist[i] < d) i++;
    if (i >= tab_count) return longint'(tab_focus[tab_count-1]);
    if (i == 0) return longint'(tab_focus[0]);
    dl = longint'(tab_dist[i-1]); du = longint'(tab_dist[i]);
    fl = longint'(tab_focus[i-1]); fu = longint'(tab_focus[i]);
    if (du <= dl) return fl;
    return fl + floor_quot((longint'(d) - dl) * (fu - fl), du - dl);
  endfunction

  function automatic out_item_t apply_beat(in_item_t b);
    out_item_t r;
    int i;
    r.status = 1'b0;
    case (b.op)
      OP_ADD: begin
        i = 0;
        while (i < tab_count && tab_dist[i] < b.distance) i++;
        if (i < tab_count && tab_dist[i] == b.distance) begin
          tab_focus[i] = b.focus_in;
        end else if (tab_count >= NPTS) begin
          r.status = 1'b1;
        end else begin
          for (int k = tab_count; k > i; k--) begin
            tab_dist[k] = tab_dist[k-1];
            tab_focus[k] = tab_focus[k-1];
          end
          tab_dist[i] = b.distance;
          tab_focus[i] = b.focus_in;
          tab_count++;
        end
      end
      OP_CLEAR: tab_count = 0;
      OP_DIST: cur_focus = clamp_focus(lookup_focus(b.distance));
      default: cur_focus = clamp_focus(longint'(b.focus_in));
    endcase
    r.focus = cur_focus;
    r.point_total = tab_count[TOTAL_W-1:0];
    return r;
  endfunction

  function automatic in_item_t make_beat(logic [OP_W-1:0] op, logic [DIST_W-1:0] d,
                                         logic [FOCUS_W-1:0] f);
    in_item_t b;
    b.op = op; b.distance = d; b.focus_in = f;
    return b;
  endfunction

  function automatic logic [DIST_W-1:0] rand_dist();
    case ($urandom_range(0, 3))
      0: return DIST_W'($urandom_range(0, 1000));
      1: return DIST_W'($urandom_range(700, 17000));
      2: return DIST_W'($urandom_range(0, 200) * 100);
      default: return DIST_W'($urandom);
    endcase
  endfunction

  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || in_taken) begin
      if (req_valid) pending_beats.pop_front();
      if (gap_left > 0) gap_left--;
      if (!hold_sender && pending_beats.size() > 0 && gap_left == 0) begin
        req_valid <= 1'b1;
        req <= pending_beats[0];
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 12);
          gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 60);
        end else begin
          burst_left--;
        end
      end else begin
        req_valid <= 1'b0;
        req <= make_beat(OP_CLEAR, DIST_W'($urandom), FOCUS_W'($urandom));
      end
    end
    rsp_stall <= ($urandom_range(0, 7) < 3) && ($urandom_range(0, 9) != 0);
  end

  always @(posedge clk) begin
    in_taken = !rst && req_valid && !req_stall;
    if (in_taken) expected_rsp.push_back(apply_beat(req));
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_rsp.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
      end else begin
        out_item_t e;
        e = expected_rsp.pop_front();
        if (rsp.focus !== e.focus) begin
          $error("focus: expected %0d, got %0d", e.focus, rsp.focus); errors++;
        end
        if (rsp.status !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, rsp.status); errors++;
        end
        if (rsp.point_total !== e.point_total) begin
          $error("point_total: expected %0d, got %0d", e.point_total, rsp.point_total);
          errors++;
        end
      end
    end
  end

  task automatic drain();
    while (pending_beats.size() != 0 || expected_rsp.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_limit(logic [CFG_ADDR_W-1:0] a, logic [FOCUS_W-1:0] v);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_addr <= a; cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (a == REG_MIN_FOCUS) lim_lo = v; else lim_hi = v;
  endtask

  task automatic random_phase(int n);
    int left;
    int n_add;
    int n_dist;
    logic [DIST_W-1:0] d;
    left = n;
    while (left > 0) begin
      if ($urandom_range(0, 3) != 0) begin
        pending_beats.push_back(make_beat(OP_CLEAR, rand_dist(), FOCUS_W'($urandom)));
        n_add = $urandom_range(1, 18);
        n_dist = $urandom_range(2, 8);
        for (int k = n_add; k > 0; k--) begin
          d = $urandom_range(0, 5) == 0 ? rand_dist() : DIST_W'($urandom_range(0, 20000));
          pending_beats.push_back(make_beat(OP_ADD, d, FOCUS_W'($urandom)));
        end
        for (int k = n_dist; k > 0; k--) begin
          pending_beats.push_back(make_beat(OP_DIST, rand_dist(), FOCUS_W'($urandom)));
        end
        left -= 1 + n_add + n_dist;
      end else begin
        pending_beats.push_back(make_beat(OP_W'($urandom), rand_dist(), FOCUS_W'($urandom)));
        left--;
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    pending_beats.push_back(make_beat(OP_DIST, 0, 0));
    pending_beats.push_back(make_beat(OP_DIST, 800, 0));
    pending_beats.push_back(make_beat(OP_DIST, 801, 0));
    pending_beats.push_back(make_beat(OP_DIST, 8400, 0));
    pending_beats.push_back(make_beat(OP_DIST, 16000, 0));
    pending_beats.push_back(make_beat(OP_DIST, 20'hFFFFF, 0));
    pending_beats.push_back(make_beat(OP_DIRECT, 0, 10'h3FF));
    pending_beats.push_back(make_beat(OP_ADD, 5000, 300));
    pending_beats.push_back(make_beat(OP_DIST, 20'hFFFFF, 0));
    pending_beats.push_back(make_beat(OP_ADD, 1000, 900));
    pending_beats.push_back(make_beat(OP_ADD, 5000, 100));
    pending_beats.push_back(make_beat(OP_DIST, 3000, 0));
    pending_beats.push_back(make_beat(OP_DIST, 0, 0));
    pending_beats.push_back(make_beat(OP_DIST, 20'hFFFFF, 0));
    pending_beats.push_back(make_beat(OP_ADD, 20'hFFFFF, 10'h3FF));
    pending_beats.push_back(make_beat(OP_ADD, 0, 0));
    for (int k = 0; k < 15; k++) begin
      pending_beats.push_back(make_beat(OP_ADD, DIST_W'(100 + k * 7), FOCUS_W'(k * 60)));
    end
    pending_beats.push_back(make_beat(OP_DIST, 140, 0));
    pending_beats.push_back(make_beat(OP_CLEAR, 0, 0));
    pending_beats.push_back(make_beat(OP_DIRECT, 0, 0));
    drain();
    hold_sender = 1'b1;
    random_phase(40);
    repeat (30) @(posedge clk);
    hold_sender = 1'b0;
    drain();
    write_limit(REG_MIN_FOCUS, 200);
    write_limit(REG_MAX_FOCUS, 700);
    random_phase(120);
    drain();
    write_limit(REG_MIN_FOCUS, 10'h3FF);
    write_limit(REG_MAX_FOCUS, 0);
    random_phase(60);
    pending_beats.push_back(make_beat(OP_CLEAR, 0, 0));
    pending_beats.push_back(make_beat(OP_DIST, 9000, 0));
    drain();
    write_limit(REG_MIN_FOCUS, 0);
    write_limit(REG_MAX_FOCUS, 10'h3FF);
    random_phase(140);
    drain();
    write_limit(REG_MIN_FOCUS, FOCUS_W'($urandom));
    write_limit(REG_MAX_FOCUS, FOCUS_W'($urandom));
    random_phase(120);
    drain();
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule
